// ===== design/hrlp_pkg.sv =====
// Package: shared types and constants for the HTTP request line parser.
package hrlp_pkg;

  // Bounds fixed by the result field widths.
  localparam int RESOURCE_MAX = 1024;
  localparam int METHOD_MAX   = 10;
  localparam int FIELD_MAX    = 255;

  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChQmark = 8'd63;
  localparam logic [7:0] ChAmp   = 8'd38;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChUpA   = 8'd65;
  localparam logic [7:0] ChUpZ   = 8'd90;

  typedef enum logic [1:0] {
    KIND_RES   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_SUM   = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    METH_GET   = 2'd0,
    METH_OTHER = 2'd1,
    METH_LONG  = 2'd2
  } method_kind_e;

  typedef enum logic [2:0] {
    MIME_NONE = 3'd0,
    MIME_HTML = 3'd1,
    MIME_CSS  = 3'd2,
    MIME_JS   = 3'd3,
    MIME_PNG  = 3'd4,
    MIME_JPEG = 3'd5,
    MIME_BMP  = 3'd6,
    MIME_ICO  = 3'd7
  } mime_class_e;

  typedef enum logic [4:0] {
    PH_METHOD = 5'b00001,
    PH_SLASH  = 5'b00010,
    PH_RES    = 5'b00100,
    PH_QUERY  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  // Result request.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [7:0]  field_index;
    logic [1:0]  method_kind;
    logic [2:0]  mime_class;
    logic        static_resource;
    logic [10:0] resource_length;
    logic [7:0]  query_fields;
    logic        overflow;
    logic        line_done;
  } result_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       is_space;
    logic       is_qmark;
    logic       is_amp;
    logic       is_dot;
    logic [7:0] lower;
  } token_t;

  function automatic logic [2:0] mime_lookup(input logic [31:0] ch, input logic [2:0] cnt);
    logic [2:0] m;
    m = MIME_NONE;
    if (cnt == 3'd4 && ch == 32'h6c6d7468) m = MIME_HTML;
    else if (cnt == 3'd3 && ch == 32'h00737363) m = MIME_CSS;
    else if (cnt == 3'd2 && ch == 32'h0000736a) m = MIME_JS;
    else if (cnt == 3'd3 && ch == 32'h00676e70) m = MIME_PNG;
    else if (cnt == 3'd3 && ch == 32'h0067706a) m = MIME_JPEG;
    else if (cnt == 3'd4 && ch == 32'h6765706a) m = MIME_JPEG;
    else if (cnt == 3'd3 && ch == 32'h00706d62) m = MIME_BMP;
    else if (cnt == 3'd3 && ch == 32'h006f6369) m = MIME_ICO;
    return m;
  endfunction

endpackage

// ===== design/hrlp_if.sv =====
// Interfaces: valid/ready channels for input bytes and results.
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic       request_start;
  logic [7:0] data_byte;
  modport source (output valid, output request_start, output data_byte, input ready);
  modport sink (input valid, input request_start, input data_byte, output ready);
endinterface

interface hrlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  out_byte;
  logic [7:0]  field_index;
  logic [1:0]  method_kind;
  logic [2:0]  mime_class;
  logic        static_resource;
  logic [10:0] resource_length;
  logic [7:0]  query_fields;
  logic        overflow;
  logic        line_done;
  modport source (output valid, output item_kind, output out_byte, output field_index,
                  output method_kind, output mime_class, output static_resource,
                  output resource_length, output query_fields, output overflow,
                  output line_done, input ready);
  modport sink (input valid, input item_kind, input out_byte, input field_index,
                input method_kind, input mime_class, input static_resource,
                input resource_length, input query_fields, input overflow,
                input line_done, output ready);
endinterface

// ===== design/hrlp_front.sv =====
// Front: classifies input bytes into tokens.
module hrlp_front import hrlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_i,
  input  logic [7:0] data_i,
  output logic       tok_valid_o,
  input  logic       tok_ready_i,
  output token_t     tok_o
);
  logic   valid_q, valid_d;
  token_t tok_q, tok_d;
  logic   load;

  assign in_ready_o = !valid_q || tok_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    tok_d          = tok_q;
    valid_d        = valid_q;
    if (tok_ready_i) valid_d = 1'b0;
    if (load) begin
      valid_d       = 1'b1;
      tok_d.start   = start_i;
      tok_d.data    = data_i;
      tok_d.is_space = data_i == ChSpace;
      tok_d.is_qmark = data_i == ChQmark;
      tok_d.is_amp  = data_i == ChAmp;
      tok_d.is_dot  = data_i == ChDot;
      tok_d.lower   = (data_i >= ChUpA && data_i <= ChUpZ) ? data_i + 8'd32 : data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;
endmodule

// ===== design/hrlp_back.sv =====
// Back: parse state machine and result register.
module hrlp_back import hrlp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    tok_valid_i,
  output logic    tok_ready_o,
  input  token_t  tok_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);
  localparam int RcW = $clog2(RESOURCE_MAX + 1);

  phase_e      phase_q, phase_d, ph;
  logic [3:0]  mcnt_q, mcnt_d, mc;
  logic        get_q, get_d, gt;
  logic [RcW-1:0] rcnt_q, rcnt_d, rc;
  logic        ldot_q, ldot_d, ld;
  logic        adot_q, adot_d, ad;
  logic [31:0] ext_q, ext_d, ex;
  logic [2:0]  ecnt_q, ecnt_d, ec;
  logic [7:0]  fcnt_q, fcnt_d, fc;
  logic        ovf_q, ovf_d, ov;
  logic        rv_q, rv_d;
  result_t     res_q, res_d;
  logic        take;

  assign tok_ready_o = !rv_q || res_ready_i;
  assign take        = tok_valid_i && tok_ready_o;

  always_comb begin
    ph = phase_q; mc = mcnt_q; gt = get_q; rc = rcnt_q; ld = ldot_q; ad = adot_q;
    ex = ext_q; ec = ecnt_q; fc = fcnt_q; ov = ovf_q;
    if (tok_i.start) begin
      ph = PH_METHOD; mc = '0; gt = 1'b1; rc = '0; ld = 1'b0; ad = 1'b0;
      ex = '0; ec = '0; fc = '0; ov = 1'b0;
    end
    phase_d = ph; mcnt_d = mc; get_d = gt; rcnt_d = rc; ldot_d = ld; adot_d = ad;
    ext_d = ex; ecnt_d = ec; fcnt_d = fc; ovf_d = ov;
    rv_d  = rv_q && !res_ready_i;
    res_d = res_q;
    if (take) begin
      res_d = '0;
      unique case (ph)
        PH_METHOD: begin
          if (tok_i.is_space) begin
            if (mc != 4'd3) get_d = 1'b0;
            phase_d = PH_SLASH;
          end else begin
            if (mc >= 4'd3) get_d = 1'b0;
            else if (mc == 4'd0 && tok_i.data != 8'd71) get_d = 1'b0;
            else if (mc == 4'd1 && tok_i.data != 8'd69) get_d = 1'b0;
            else if (mc == 4'd2 && tok_i.data != 8'd84) get_d = 1'b0;
            if (32'(mc) <= METHOD_MAX) mcnt_d = mc + 4'd1;
          end
        end
        PH_SLASH: phase_d = PH_RES;
        PH_RES, PH_QUERY: begin
          if (tok_i.is_space) begin
            rv_d = 1'b1;
            phase_d = PH_DONE;
            res_d.item_kind = KIND_SUM;
            res_d.line_done = 1'b1;
            res_d.overflow  = ov;
            res_d.method_kind = gt ? METH_GET :
                                (32'(mc) > METHOD_MAX ? METH_LONG : METH_OTHER);
            if (gt) begin
              res_d.mime_class = (rc < RcW'(4) || !ld) ? MIME_NONE : mime_lookup(ex, ec);
              res_d.static_resource = (rc == '0) || ad;
              res_d.resource_length = 11'(rc);
              res_d.query_fields = (ph == PH_QUERY) ? fc : 8'd0;
            end else begin
              res_d.static_resource = 1'b1;
            end
          end else if (ph == PH_QUERY) begin
            if (tok_i.is_amp) begin
              if (32'(fc) < FIELD_MAX) fcnt_d = fc + 8'd1;
              else ovf_d = 1'b1;
            end else begin
              rv_d = 1'b1;
              res_d.item_kind   = KIND_QUERY;
              res_d.out_byte    = tok_i.data;
              res_d.field_index = fc - 8'd1;
            end
          end else if (gt) begin
            if (tok_i.is_qmark) begin
              phase_d = PH_QUERY;
              fcnt_d  = 8'd1;
            end else if (32'(rc) >= RESOURCE_MAX) begin
              ovf_d = 1'b1;
            end else begin
              rcnt_d = rc + RcW'(1);
              if (tok_i.is_dot) begin
                adot_d = 1'b1;
                if (rc != '0) begin
                  ldot_d = 1'b1; ext_d = '0; ecnt_d = '0;
                end
              end else begin
                if (ec < 3'd4) ext_d = ex | (32'(tok_i.lower) << {ec[1:0], 3'b000});
                if (ec < 3'd5) ecnt_d = ec + 3'd1;
              end
              rv_d = 1'b1;
              res_d.item_kind = KIND_RES;
              res_d.out_byte  = tok_i.data;
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD; mcnt_q <= '0; get_q <= 1'b1; rcnt_q <= '0;
      ldot_q <= 1'b0; adot_q <= 1'b0; ext_q <= '0; ecnt_q <= '0;
      fcnt_q <= '0; ovf_q <= 1'b0; rv_q <= 1'b0;
    end else if (take || rv_q) begin
      rv_q <= rv_d;
      if (take) begin
        phase_q <= phase_d; mcnt_q <= mcnt_d; get_q <= get_d; rcnt_q <= rcnt_d;
        ldot_q <= ldot_d; adot_q <= adot_d; ext_q <= ext_d; ecnt_q <= ecnt_d;
        fcnt_q <= fcnt_d; ovf_q <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !res_ready_i |=> rv_q && $stable(res_q)) else $error("result dropped");
  a_rcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rcnt_q) <= RESOURCE_MAX) else $error("resource count over bound");
  a_fcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fcnt_q) <= FIELD_MAX) else $error("field count over bound");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && res_d.line_done && rv_d |=> phase_q == PH_DONE) else $error("summary w/o done");
`endif
endmodule

// ===== design/http_request_line_parser_top.sv =====
// An accepted byte passes through the front token register, then the result register.
// Throughput: one byte per cycle when no result is held, set by the back's parse update.
// Front classifier register and result register each act as one-entry stages; a held
// result stalls the back and, through the ready chain, the input once the front is full.
// Reset (rst_ni, async low) empties both stages and returns the parse to the method phase.
// request_start on a byte restarts the parse at that byte.
module http_request_line_parser_top import hrlp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  hrlp_in_if.sink  in_i,
  hrlp_out_if.source out_o
);
  logic    tok_valid, tok_ready;
  token_t  tok;
  result_t res;

  // Front: byte classification.
  hrlp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .start_i    (in_i.request_start),
    .data_i     (in_i.data_byte),
    .tok_valid_o(tok_valid),
    .tok_ready_i(tok_ready),
    .tok_o      (tok)
  );

  // Back: parse state and result register.
  hrlp_back u_back (
    .clk_i, .rst_ni,
    .tok_valid_i(tok_valid),
    .tok_ready_o(tok_ready),
    .tok_i      (tok),
    .res_valid_o(out_o.valid),
    .res_ready_i(out_o.ready),
    .res_o      (res)
  );

  assign out_o.item_kind       = res.item_kind;
  assign out_o.out_byte        = res.out_byte;
  assign out_o.field_index     = res.field_index;
  assign out_o.method_kind     = res.method_kind;
  assign out_o.mime_class      = res.mime_class;
  assign out_o.static_resource = res.static_resource;
  assign out_o.resource_length = res.resource_length;
  assign out_o.query_fields    = res.query_fields;
  assign out_o.overflow        = res.overflow;
  assign out_o.line_done       = res.line_done;
endmodule
